>>> rtl/core/dspe_pkg.sv
package dspe_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;

    localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;
    localparam logic [31:0] DIST_SAT = 32'hFFFF_FFFE;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [2:0] ST_REPORT  = 3'd0;
    localparam logic [2:0] ST_ACCEPT  = 3'd1;
    localparam logic [2:0] ST_REJECT  = 3'd2;
    localparam logic [2:0] ST_CLEARED = 3'd3;
    localparam logic [2:0] ST_BADSRC  = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  edge_tail;
        logic [5:0]  edge_head;
        logic [15:0] edge_length;
        logic [15:0] edge_label;
        logic [5:0]  source_vertex;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  vertex;
        logic        reached;
        logic [31:0] distance;
        logic        has_parent;
        logic [5:0]  parent_vertex;
        logic [15:0] parent_edge;
        logic        last;
    } t_out_item;

    // Saturating path sum.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        if (s > {1'b0, DIST_SAT}) begin
            return DIST_SAT;
        end
        return s[31:0];
    endfunction

endpackage

>>> rtl/core/dspe_stream_if.sv
interface dspe_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/dspe_ram.sv
module dspe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/dijkstra_shortest_path_engine_core.sv
// Channel  | Direction | Payload                                   | Transaction
// ---------+-----------+-------------------------------------------+------------------
// i_in     | sink      | command, edge fields, source_vertex        | valid & ready
// o_out    | source    | status, vertex, distance, parent, last     | valid & ready
// i_cfg    | sink      | vertex_count (7 bits)                      | valid & ready
//
// Clear and add-edge commands, and a run with a bad source, are each accepted,
// then give one result held in the output register until it is taken.
// A run is sequential. Each extraction is a selection sweep over the n vertices (one
// vertex memory read per cycle), a state that starts the edge sweep, and for each
// stored edge an edge read, then a tail read and relax. After the last extraction a
// last sweep finds nothing, and then every vertex passes the read, load and present
// states, staying in present while o_out.ready is held low.
// Reset is synchronous, active low; the edge and vertex memories are not cleared,
// since a vertex entry is read only after the current run has written it.
// Input and configuration are not ready while a command is being worked or a
// result waits.
module dijkstra_shortest_path_engine_core
    import dspe_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dspe_stream_if.sink   i_in,
    dspe_stream_if.source o_out,
    dspe_stream_if.sink   i_cfg
);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int EC = $clog2(MAX_EDGES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RESULT, S_SELECT, S_SCAN_E, S_SCAN_V, S_SCAN_U,
        S_RPT_RD, S_RPT_LD, S_RPT
    } t_state;

    t_state          r_state;
    logic [6:0]      r_vcount;
    logic [EC-1:0]   r_etotal;
    logic [MAX_VERTICES-1:0] r_lab, r_scn;
    logic [6:0]      r_n;
    logic [5:0]      r_src;
    logic [6:0]      r_vi;
    logic [6:0]      r_vq;
    logic [6:0]      r_best;
    logic [31:0]     r_bdist;
    logic [EC-1:0]   r_ei;
    logic            r_rdv;
    t_out_item       r_out;

    t_in_item in_d;
    assign in_d = t_in_item'(i_in.data);

    // Edge memory: one row holds tail, head, length and label.
    logic          e_we;
    logic [EW-1:0] e_waddr, e_raddr;
    logic [43:0]   e_wdata, e_rdata;

    dspe_ram #(.WIDTH(44), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk  (i_clk),
        .i_we   (e_we),
        .i_waddr(e_waddr),
        .i_wdata(e_wdata),
        .i_raddr(e_raddr),
        .o_rdata(e_rdata)
    );

    // Vertex memory: one row holds distance, parent vertex and parent edge label.
    logic          v_we;
    logic [VW-1:0] v_waddr, v_raddr;
    logic [53:0]   v_wdata, v_rdata;

    dspe_ram #(.WIDTH(54), .DEPTH(MAX_VERTICES)) u_vertices (
        .i_clk  (i_clk),
        .i_we   (v_we),
        .i_waddr(v_waddr),
        .i_wdata(v_wdata),
        .i_raddr(v_raddr),
        .o_rdata(v_rdata)
    );

    wire in_fire = i_in.valid && i_in.ready;
    wire [6:0] act_n = (r_vcount == 7'd0) ? 7'd1 :
        (r_vcount > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : r_vcount;
    wire run_ok = in_fire && (t_cmd'(in_d.command) == CMD_RUN)
                  && ({1'b0, in_d.source_vertex} < act_n);

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_RESULT) || (r_state == S_RPT);
    assign o_out.data  = r_out;

    wire [EC-1:0] ei_nx = r_ei + 1'b1;

    assign e_we    = in_fire && (t_cmd'(in_d.command) == CMD_ADD)
                     && (r_etotal < EC'(MAX_EDGES))
                     && ({1'b0, in_d.edge_tail} < 7'(MAX_VERTICES))
                     && ({1'b0, in_d.edge_head} < 7'(MAX_VERTICES));
    assign e_waddr = r_etotal[EW-1:0];
    assign e_wdata = {in_d.edge_tail, in_d.edge_head, in_d.edge_length, in_d.edge_label};
    // While relaxing, the next edge is already being fetched.
    assign e_raddr = (r_state == S_SCAN_U) ? ei_nx[EW-1:0] : r_ei[EW-1:0];

    // Edge fields of row r_ei, valid in S_SCAN_V and S_SCAN_U.
    wire [5:0]  e_t = e_rdata[43:38];
    wire [5:0]  e_h = e_rdata[37:32];
    wire [15:0] e_l = e_rdata[31:16];
    wire [15:0] e_b = e_rdata[15:0];
    wire [VW-1:0] t_ix = e_t[VW-1:0];
    wire [VW-1:0] vi_ix = r_vi[VW-1:0];
    wire [VW-1:0] vq_ix = r_vq[VW-1:0];

    wire [31:0] v_dist = v_rdata[53:22];
    wire [5:0]  v_pv   = v_rdata[21:16];
    wire [15:0] v_pe   = v_rdata[15:0];

    wire [31:0] e_sum = sat_add(r_bdist, e_l);
    // In S_SCAN_U the vertex row of the edge tail has arrived.
    wire relax = ({1'b0, e_h} == r_best) && ({1'b0, e_t} < r_n)
                 && !r_scn[t_ix] && (!r_lab[t_ix] || v_dist > e_sum);

    // The tail is read in S_SCAN_V, every other read walks r_vi.
    assign v_raddr = (r_state == S_SCAN_V) ? t_ix : vi_ix;
    assign v_we    = run_ok || ((r_state == S_SCAN_U) && relax);
    assign v_waddr = (r_state == S_IDLE) ? in_d.source_vertex[VW-1:0] : t_ix;
    assign v_wdata = (r_state == S_IDLE) ? 54'd0 : {e_sum, r_best[5:0], e_b};

    // Selection: the row of vertex r_vq arrives in the cycle after its read.
    wire cand = r_rdv && r_lab[vq_ix] && !r_scn[vq_ix] &&
        (r_best == r_n || v_dist < r_bdist);
    wire [6:0]  n_best  = cand ? r_vq : r_best;
    wire [31:0] n_bdist = cand ? v_dist : r_bdist;
    wire [VW-1:0] nb_ix = n_best[VW-1:0];

    wire rpt_par = r_lab[vi_ix] && (r_vi[5:0] != r_src);

    function automatic t_out_item single(input logic [2:0] st);
        t_out_item o;
        o = '0;
        o.status = st;
        o.distance = DIST_INF;
        o.last = 1'b1;
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= 7'd64;
            r_etotal <= '0;
            r_lab    <= '0;
            r_scn    <= '0;
            r_rdv    <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_vcount <= i_cfg.data[6:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (t_cmd'(in_d.command))
                            CMD_CLEAR: begin
                                r_etotal <= '0;
                                r_out    <= single(ST_CLEARED);
                                r_state  <= S_RESULT;
                            end
                            CMD_ADD: begin
                                if (e_we) begin
                                    r_etotal <= r_etotal + 1'b1;
                                    r_out    <= single(ST_ACCEPT);
                                end else begin
                                    r_out    <= single(ST_REJECT);
                                end
                                r_state <= S_RESULT;
                            end
                            CMD_RUN: begin
                                if (!run_ok) begin
                                    r_out   <= single(ST_BADSRC);
                                    r_state <= S_RESULT;
                                end else begin
                                    // The source row is written with distance zero
                                    // through the vertex memory port.
                                    r_lab  <= {{(MAX_VERTICES-1){1'b0}}, 1'b1}
                                              << in_d.source_vertex[VW-1:0];
                                    r_scn  <= '0;
                                    r_n    <= act_n;
                                    r_src  <= in_d.source_vertex;
                                    r_vi   <= '0;
                                    r_rdv  <= 1'b0;
                                    r_best <= act_n;
                                    r_state <= S_SELECT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RESULT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SELECT: begin
                    r_best  <= n_best;
                    r_bdist <= n_bdist;
                    if (r_vi < r_n) begin
                        r_vq  <= r_vi;
                        r_vi  <= r_vi + 1'b1;
                        r_rdv <= 1'b1;
                    end else if (n_best == r_n) begin
                        r_rdv   <= 1'b0;
                        r_vi    <= '0;
                        r_state <= S_RPT_RD;
                    end else begin
                        r_scn[nb_ix] <= 1'b1;
                        r_rdv   <= 1'b0;
                        r_ei    <= '0;
                        r_state <= S_SCAN_E;
                    end
                end
                S_SCAN_E: begin
                    if (r_ei < r_etotal) begin
                        r_state <= S_SCAN_V;
                    end else begin
                        r_vi    <= '0;
                        r_best  <= r_n;
                        r_state <= S_SELECT;
                    end
                end
                S_SCAN_V: begin
                    r_state <= S_SCAN_U;
                end
                S_SCAN_U: begin
                    if (relax) begin
                        r_lab[t_ix] <= 1'b1;
                    end
                    if (ei_nx < r_etotal) begin
                        r_ei    <= ei_nx;
                        r_state <= S_SCAN_V;
                    end else begin
                        r_vi    <= '0;
                        r_best  <= r_n;
                        r_state <= S_SELECT;
                    end
                end
                S_RPT_RD: begin
                    r_state <= S_RPT_LD;
                end
                S_RPT_LD: begin
                    r_out.status        <= ST_REPORT;
                    r_out.vertex        <= r_vi[5:0];
                    r_out.reached       <= r_lab[vi_ix];
                    r_out.distance      <= r_lab[vi_ix] ? v_dist : DIST_INF;
                    r_out.has_parent    <= rpt_par;
                    r_out.parent_vertex <= rpt_par ? v_pv : 6'd0;
                    r_out.parent_edge   <= rpt_par ? v_pe : 16'd0;
                    r_out.last          <= (r_vi + 1'b1 == r_n);
                    r_state <= S_RPT;
                end
                S_RPT: begin
                    if (o_out.ready) begin
                        if (r_out.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_vi    <= r_vi + 1'b1;
                            r_state <= S_RPT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> dv/tb_dijkstra_shortest_path_engine_core.sv
`timescale 1ns / 1ps

// Scoreboard for the shortest path engine. It keeps its own edge table, vertex
// count and walk state, works out every result that an accepted command causes,
// and checks each result that leaves the block against the oldest expectation.
class path_scoreboard;
    localparam int NV = dspe_pkg::MAX_VERTICES_DEF;
    localparam int NE = dspe_pkg::MAX_EDGES_DEF;

    logic [5:0]  tail_tab[NE];
    logic [5:0]  head_tab[NE];
    logic [15:0] len_tab[NE];
    logic [15:0] lbl_tab[NE];
    int          edge_cnt;
    logic [6:0]  vcount;
    logic [31:0] vdist[NV];
    bit          labeled[NV];
    bit          scanned[NV];
    logic [5:0]  par_v[NV];
    logic [15:0] par_e[NV];

    dspe_pkg::t_out_item pending[$];
    int errors;
    int checked;
    int runs;

    function void reset_state();
        edge_cnt = 0;
        vcount   = 7'd64;
        pending.delete();
        errors   = 0;
        checked  = 0;
        runs     = 0;
    endfunction

    function void set_count(logic [6:0] value);
        vcount = value;
    endfunction

    function int used_vertices();
        if (vcount == 0) return 1;
        if (vcount > NV) return NV;
        return vcount;
    endfunction

    function void push_single(logic [2:0] status);
        dspe_pkg::t_out_item r;
        r = '0;
        r.status   = status;
        r.distance = dspe_pkg::DIST_INF;
        r.last     = 1'b1;
        pending.push_back(r);
    endfunction

    function void walk(int src, int n);
        int best;
        int t;
        logic [32:0] sum;
        for (int i = 0; i < NV; i++) begin
            vdist[i] = dspe_pkg::DIST_INF;
            labeled[i] = 0;
            scanned[i] = 0;
        end
        vdist[src] = 0;
        labeled[src] = 1;
        forever begin
            best = n;
            for (int v = 0; v < n; v++) begin
                if (labeled[v] && !scanned[v] && (best == n || vdist[v] < vdist[best]))
                    best = v;
            end
            if (best == n) break;
            scanned[best] = 1;
            for (int e = 0; e < edge_cnt; e++) begin
                t = tail_tab[e];
                if (head_tab[e] != best || t >= n || scanned[t]) continue;
                sum = {1'b0, vdist[best]} + {17'd0, len_tab[e]};
                if (sum > {1'b0, dspe_pkg::DIST_SAT}) sum = {1'b0, dspe_pkg::DIST_SAT};
                if (!labeled[t] || {1'b0, vdist[t]} > sum) begin
                    labeled[t] = 1;
                    vdist[t]   = sum[31:0];
                    par_v[t]   = best[5:0];
                    par_e[t]   = lbl_tab[e];
                end
            end
        end
    endfunction

    // Notes one accepted command and queues what it must produce.
    function void note_command(dspe_pkg::t_in_item it);
        int n;
        dspe_pkg::t_out_item r;
        case (it.command)
            dspe_pkg::CMD_CLEAR: begin
                edge_cnt = 0;
                push_single(dspe_pkg::ST_CLEARED);
            end
            dspe_pkg::CMD_ADD: begin
                if (edge_cnt >= NE) begin
                    push_single(dspe_pkg::ST_REJECT);
                end else begin
                    tail_tab[edge_cnt] = it.edge_tail;
                    head_tab[edge_cnt] = it.edge_head;
                    len_tab[edge_cnt]  = it.edge_length;
                    lbl_tab[edge_cnt]  = it.edge_label;
                    edge_cnt++;
                    push_single(dspe_pkg::ST_ACCEPT);
                end
            end
            dspe_pkg::CMD_RUN: begin
                n = used_vertices();
                if (it.source_vertex >= n) begin
                    push_single(dspe_pkg::ST_BADSRC);
                end else begin
                    runs++;
                    walk(it.source_vertex, n);
                    for (int v = 0; v < n; v++) begin
                        r = '0;
                        r.status   = dspe_pkg::ST_REPORT;
                        r.vertex   = v[5:0];
                        r.reached  = labeled[v];
                        r.distance = labeled[v] ? vdist[v] : dspe_pkg::DIST_INF;
                        r.has_parent = labeled[v] && v != it.source_vertex;
                        if (r.has_parent) begin
                            r.parent_vertex = par_v[v];
                            r.parent_edge   = par_e[v];
                        end
                        r.last = (v + 1 == n);
                        pending.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch: %s got %0h expected %0h (result %0d)", what, got, want, checked);
    endtask

    task check_result(dspe_pkg::t_out_item got);
        dspe_pkg::t_out_item w;
        checked++;
        if (pending.size() == 0) begin
            report("unexpected result, status", got.status, 0);
            return;
        end
        w = pending.pop_front();
        if (got.status !== w.status) report("status", got.status, w.status);
        if (got.vertex !== w.vertex) report("vertex", got.vertex, w.vertex);
        if (got.reached !== w.reached) report("reached", got.reached, w.reached);
        if (got.distance !== w.distance) report("distance", got.distance, w.distance);
        if (got.has_parent !== w.has_parent)
            report("has_parent", got.has_parent, w.has_parent);
        if (got.parent_vertex !== w.parent_vertex)
            report("parent_vertex", got.parent_vertex, w.parent_vertex);
        if (got.parent_edge !== w.parent_edge)
            report("parent_edge", got.parent_edge, w.parent_edge);
        if (got.last !== w.last) report("last", got.last, w.last);
    endtask
endclass

module tb_dijkstra_shortest_path_engine_core;
    import dspe_pkg::*;

    logic i_clk;
    logic i_rst_n;

    dspe_stream_if #(.W($bits(t_in_item)))  cmd_ch ();
    dspe_stream_if #(.W($bits(t_out_item))) res_ch ();
    dspe_stream_if #(.W(7))                 cfg_ch ();

    dijkstra_shortest_path_engine_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch.sink),
        .o_out   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    path_scoreboard sb;

    // Stall control for the result side: a random pattern, a mode with no
    // stalls at all, and a long forced hold-off used once to fill the block.
    int  stall_mode;
    bit  hold_off;
    bit  sender_busy_gaps;
    int  vc_low_seen;
    int  vc_high_seen;
    realtime cmd_drop_at;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // A generous ceiling for the whole test: there are a few dozen runs at most.
    initial begin
        #400ms;
        $display("*** FAILED ***");
        $finish;
    end

    // The result side is sampled at the rising edge; every transaction is
    // handed to the scoreboard in the same place.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_result(t_out_item'(res_ch.data));
        end
    end

    // Command transactions are recorded as they are accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            sb.note_command(t_in_item'(cmd_ch.data));
        end
    end

    // The ready pattern of the receiver changes at the falling edge only.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) res_ch.ready <= 1'b0;
            else if (stall_mode == 0) res_ch.ready <= 1'b1;
            else res_ch.ready <= ($urandom_range(0, 99) >= stall_mode);
        end
    end

    // Drives one command; returns once the block has taken it. A command that
    // follows straight on waits for the next falling edge, so valid is driven
    // only once in a time step; the block is busy in that cycle anyway.
    task send_cmd(t_in_item it);
        if ($realtime == cmd_drop_at) @(negedge i_clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= it;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        cmd_drop_at = $realtime;
    endtask

    // Same, but the sender sometimes idles first, so that the
    // gaps land on every phase of a command.
    task offer_cmd(t_in_item it);
        if (sender_busy_gaps && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        send_cmd(it);
    endtask

    function t_in_item make_edge(int tail, int head, int len, int lbl);
        t_in_item it;
        it = '0;
        it.command     = CMD_ADD;
        it.edge_tail   = tail[5:0];
        it.edge_head   = head[5:0];
        it.edge_length = len[15:0];
        it.edge_label  = lbl[15:0];
        return it;
    endfunction

    function t_in_item make_cmd(t_cmd c, int src);
        t_in_item it;
        it = '0;
        it.command       = c;
        it.source_vertex = src[5:0];
        // Noise in the fields that this command ignores.
        it.edge_tail   = 6'($urandom);
        it.edge_head   = 6'($urandom);
        it.edge_length = 16'($urandom);
        it.edge_label  = 16'($urandom);
        return it;
    endfunction

    // Waits until every expected result has come, then lets the block settle;
    // a command with no result (the unused code) is taken without any work.
    task drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task write_count(logic [6:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.set_count(value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (value <= 7'd2) vc_low_seen++;
        if (value >= 7'd64) vc_high_seen++;
    endtask

    // One random graph: a clear, a burst of edges whose endpoints mostly fall
    // inside the current vertex count, then a few runs from random sources.
    task automatic random_graph(int nvert, int nedges, ref int items);
        int src;
        offer_cmd(make_cmd(CMD_CLEAR, 0));
        items++;
        for (int i = 0; i < nedges; i++) begin
            if ($urandom_range(0, 9) == 0)
                offer_cmd(make_edge($urandom_range(0, 63), $urandom_range(0, 63),
                                    $urandom, $urandom));
            else if ($urandom_range(0, 7) == 0)
                offer_cmd(make_edge($urandom_range(0, nvert - 1),
                                    $urandom_range(0, nvert - 1),
                                    $urandom_range(65000, 65535), $urandom));
            else
                offer_cmd(make_edge($urandom_range(0, nvert - 1),
                                    $urandom_range(0, nvert - 1),
                                    $urandom_range(0, 20), $urandom));
            items++;
            // Bursts with random gaps between them.
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        repeat ($urandom_range(1, 3)) begin
            src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                              : $urandom_range(0, nvert - 1);
            offer_cmd(make_cmd(CMD_RUN, src));
            items++;
        end
        if ($urandom_range(0, 4) == 0) begin
            offer_cmd(make_cmd(CMD_NONE, $urandom_range(0, 63)));
            items++;
        end
    endtask

    initial begin
        int items;
        int nv;
        sb = new();
        sb.reset_state();
        items = 0;
        vc_low_seen = 0;
        vc_high_seen = 0;
        stall_mode = 0;
        hold_off = 1'b0;
        sender_busy_gaps = 1'b0;
        cmd_drop_at = -1.0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. A run at reset count 64 over an empty table leaves
        // every vertex but the source unreached.
        send_cmd(make_cmd(CMD_RUN, 63));
        send_cmd(make_cmd(CMD_NONE, 5));
        write_count(7'd4);
        // Tie on distance: vertices 1 and 2 both at 5; vertex 1 is extracted
        // first, so 3 gets its parent through 1. A later equal edge does not
        // replace the parent.
        send_cmd(make_edge(1, 0, 5, 16'h0001));
        send_cmd(make_edge(2, 0, 5, 16'h0002));
        send_cmd(make_edge(3, 1, 1, 16'h0003));
        send_cmd(make_edge(3, 2, 1, 16'h0004));
        send_cmd(make_edge(3, 0, 65535, 16'hFFFF));
        send_cmd(make_edge(63, 0, 0, 16'h0005));   // endpoint beyond the count
        send_cmd(make_cmd(CMD_RUN, 0));
        send_cmd(make_cmd(CMD_RUN, 3));
        send_cmd(make_cmd(CMD_RUN, 4));             // bad source
        write_count(7'd0);                          // acts as one vertex
        send_cmd(make_cmd(CMD_RUN, 0));
        send_cmd(make_cmd(CMD_RUN, 1));
        write_count(7'd127);                        // acts as the maximum
        send_cmd(make_cmd(CMD_RUN, 0));
        send_cmd(make_cmd(CMD_CLEAR, 0));
        // The longest edge length, run from each end of the edge.
        write_count(7'd2);
        send_cmd(make_edge(1, 0, 65535, 16'hABCD));
        send_cmd(make_cmd(CMD_RUN, 0));
        send_cmd(make_cmd(CMD_RUN, 1));
        items = 18;

        // Table full: fill all entries, then one more is refused.
        drain();
        write_count(7'd64);
        stall_mode = 30;
        send_cmd(make_cmd(CMD_CLEAR, 0));
        for (int i = 0; i < 257; i++)
            send_cmd(make_edge($urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom, $urandom));
        send_cmd(make_cmd(CMD_RUN, $urandom_range(0, 63)));
        items += 259;

        // Long hold-off on the result side while the sender keeps offering.
        drain();
        write_count(7'd8);
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_cmd(make_cmd(CMD_CLEAR, 0));
                for (int i = 0; i < 6; i++)
                    send_cmd(make_edge($urandom_range(0, 7), $urandom_range(0, 7),
                                       $urandom_range(0, 9), $urandom));
                send_cmd(make_cmd(CMD_RUN, 0));
            end
        join
        items += 8;

        // Random part over several vertex counts; the sender pauses until
        // every expected result has come before each new count.
        sender_busy_gaps = 1'b1;
        while (items < 330) begin
            case ($urandom_range(0, 5))
                0: nv = 1;
                1: nv = 2;
                2: nv = 64;
                default: nv = $urandom_range(3, 16);
            endcase
            write_count(nv[6:0]);
            stall_mode = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
            random_graph(nv, (nv == 64) ? $urandom_range(20, 60) : $urandom_range(0, 3 * nv),
                         items);
        end

        drain();
        repeat (200) @(negedge i_clk);
        $display("Covered %0d directed and random commands, %0d graph runs, %0d results.",
                 items, sb.runs, sb.checked);
        $display("Vertex counts at the low end %0d times, at the top %0d times.",
                 vc_low_seen, vc_high_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/core/dspe_pkg.sv
rtl/core/dspe_stream_if.sv
rtl/core/dspe_ram.sv
rtl/core/dijkstra_shortest_path_engine_core.sv
dv/tb_dijkstra_shortest_path_engine_core.sv
